@@ src/assert_macros.svh @@
// Assertion shorthand used by the hash table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/lpht_pkg.sv @@
package lpht_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int SIZE_W    = SLOT_W + 1;
   localparam int KEY_W     = 31;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int TAG_W     = 2;
   localparam int SIZE_RESET = 10;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
   localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
   localparam logic [TAG_W-1:0] TAG_GONE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISS        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_REMOVE_MISS = 3'd5;

   // Sequencer program counter and step addresses.
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [PC_W-1:0] STEP_DIV   = 3'd1;
   localparam logic [PC_W-1:0] STEP_HOME  = 3'd2;
   localparam logic [PC_W-1:0] STEP_PROBE = 3'd3;
   localparam logic [PC_W-1:0] STEP_EMIT  = 3'd4;

   // Jump conditions: when true the sequencer goes to the target step.
   typedef enum logic [2:0] {
      COND_NONE,
      COND_NO_REQ,
      COND_REM_BUSY,
      COND_OP_BAD,
      COND_PROBING,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      cond_type          cond;
      logic [PC_W-1:0]   target;
      logic              last;
      logic              home;
      logic              probe;
      logic              emit;
   } ctrl_word_type;

   // Control store. Unused addresses fall back to the idle step.
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{cond: COND_NONE, target: STEP_IDLE, last: 1'b1,
            home: 1'b0, probe: 1'b0, emit: 1'b0};
      case (pc)
         STEP_IDLE: begin
            w = '{cond: COND_NO_REQ, target: STEP_IDLE, last: 1'b0,
                  home: 1'b0, probe: 1'b0, emit: 1'b0};
         end
         STEP_DIV: begin
            w = '{cond: COND_REM_BUSY, target: STEP_DIV, last: 1'b0,
                  home: 1'b0, probe: 1'b0, emit: 1'b0};
         end
         STEP_HOME: begin
            w = '{cond: COND_OP_BAD, target: STEP_EMIT, last: 1'b0,
                  home: 1'b1, probe: 1'b0, emit: 1'b0};
         end
         STEP_PROBE: begin
            w = '{cond: COND_PROBING, target: STEP_PROBE, last: 1'b0,
                  home: 1'b0, probe: 1'b1, emit: 1'b0};
         end
         STEP_EMIT: begin
            w = '{cond: COND_OUT_BUSY, target: STEP_EMIT, last: 1'b1,
                  home: 1'b0, probe: 1'b0, emit: 1'b1};
         end
         default: begin
            w = '{cond: COND_NONE, target: STEP_IDLE, last: 1'b1,
                  home: 1'b0, probe: 1'b0, emit: 1'b0};
         end
      endcase
      return w;
   endfunction

endpackage

@@ src/linear_probe_hash_table.sv @@
// Channel  | Ports                               | Direction | Handshake
// request  | req_valid, req_stall, req_op/key    | in        | valid high, stall low
// response | rsp_valid, rsp_stall, rsp_status/.. | out       | valid high, stall low
// csr      | csr_wr_en, csr_wr_data              | in        | write on enable, no wait
//
// A request is answered after the remainder step (31 dividend bits, then a look to see the
// unit finish), a step that loads the home slot, the probes (1 up to table size, none for
// the unused opcode) and the hand-over. The next request is taken only once the sequence
// is back in the idle step after the hand-over. Reset empties every slot at once (tags are
// flip-flops) and sets the size to 10. A stalled response waits in the output register while
// the next request runs.
`include "assert_macros.svh"

module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_index,
   input  logic                csr_wr_en,
   input  logic [SIZE_W-1:0]   csr_wr_data
);

   // Sequencer state.
   logic [PC_W-1:0]     pc_ff, pc_in;
   ctrl_word_type       cw;
   logic                cond_true;

   // Request held for the duration of the sequence.
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;

   // Table size minus one, kept already clamped into the usable range.
   logic [SLOT_W-1:0]   size_m1_ff, size_m1_in;

   // Probe datapath.
   logic [SLOT_W-1:0]   pos_ff, pos_in;
   logic [SLOT_W-1:0]   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]   pos_next;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   // Slot storage: tags in flip-flops so that reset empties them at once,
   // keys in a memory with a registered read port.
   logic [TAG_W-1:0]    tag_ff [MAX_SLOTS];
   logic [TAG_W-1:0]    tag_in [MAX_SLOTS];
   logic [KEY_W-1:0]    key_mem [MAX_SLOTS];
   logic [KEY_W-1:0]    key_rd_ff;
   logic                key_we;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   // Remainder unit handshake.
   logic                req_accept;
   logic                rem_busy;
   logic [SLOT_W-1:0]   rem_value;
   logic [SIZE_W-1:0]   divisor;

   // Probe decode.
   logic [TAG_W-1:0]    tag_cur;
   logic                is_insert;
   logic                last_probe;
   logic                probe_hit;
   logic                probe_stop;
   logic                out_busy;
   logic                emit_fire;

   assign req_stall  = (pc_ff != STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign divisor    = {1'b0, size_m1_ff} + SIZE_W'(1);

   lpht_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .dividend  (req_key),
      .divisor   (divisor),
      .busy      (rem_busy),
      .remainder (rem_value)
   );

   // The current control word comes straight from the control store.
   assign cw = ucode(pc_ff);

   // Probe evaluation. An insert stops at the first slot that is not
   // occupied; search and remove stop at an empty slot or a matching key,
   // and deleted slots are passed over. Every probe sequence gives up once
   // each slot in use has been looked at.
   always_comb begin
      tag_cur    = tag_ff[pos_ff];
      is_insert  = (op_ff == OP_INSERT);
      last_probe = (cnt_ff == size_m1_ff);
      pos_next   = (pos_ff == size_m1_ff) ? '0 : pos_ff + 1'b1;
      if (is_insert) begin
         probe_hit  = (tag_cur != TAG_USED);
         probe_stop = probe_hit || last_probe;
      end else begin
         probe_hit  = (tag_cur == TAG_USED) && (key_rd_ff == key_ff);
         probe_stop = probe_hit || (tag_cur == TAG_EMPTY) || last_probe;
      end
   end

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign emit_fire = cw.emit && !out_busy;

   always_comb begin
      case (cw.cond)
         COND_NONE:     cond_true = 1'b0;
         COND_NO_REQ:   cond_true = !req_accept;
         COND_REM_BUSY: cond_true = rem_busy;
         COND_OP_BAD:   cond_true = (op_ff == OP_UNUSED);
         COND_PROBING:  cond_true = !probe_stop;
         COND_OUT_BUSY: cond_true = out_busy;
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (cond_true) begin
         pc_in = cw.target;
      end else if (cw.last) begin
         pc_in = STEP_IDLE;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // Configuration: a size of zero behaves as one slot, and anything above
   // the table depth behaves as the full depth.
   always_comb begin
      size_m1_in = size_m1_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            size_m1_in = '0;
         end else if (csr_wr_data > SIZE_W'(MAX_SLOTS)) begin
            size_m1_in = SLOT_W'(MAX_SLOTS - 1);
         end else begin
            size_m1_in = SLOT_W'(csr_wr_data - 1'b1);
         end
      end
   end

   // Datapath driven by the control word.
   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      tag_in    = tag_ff;
      key_we    = 1'b0;

      if (req_accept) begin
         op_in  = req_op;
         key_in = req_key;
      end

      // Home slot: load the probe position and preset the answer for the
      // case where no slot is hit.
      if (cw.home) begin
         pos_in  = rem_value;
         cnt_in  = '0;
         slot_in = '0;
         case (op_ff)
            OP_INSERT: status_in = ST_FULL;
            OP_REMOVE: status_in = ST_REMOVE_MISS;
            default:   status_in = ST_MISS;
         endcase
      end

      if (cw.probe) begin
         if (probe_hit) begin
            slot_in = pos_ff;
            case (op_ff)
               OP_INSERT: begin
                  status_in      = ST_INSERTED;
                  tag_in[pos_ff] = TAG_USED;
                  key_we         = 1'b1;
               end
               OP_REMOVE: begin
                  status_in      = ST_REMOVED;
                  tag_in[pos_ff] = TAG_GONE;
               end
               default: begin
                  status_in = ST_FOUND;
               end
            endcase
         end else if (!probe_stop) begin
            pos_in = pos_next;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // Output register: loaded when the sequence hands over its answer and the
   // previous response has gone.
   always_comb begin
      rsp_valid_in  = emit_fire || out_busy;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (emit_fire) begin
         rsp_status_in = status_ff;
         rsp_slot_in   = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         size_m1_ff   <= SLOT_W'(SIZE_RESET - 1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            tag_ff[i] <= TAG_EMPTY;
         end
      end else begin
         pc_ff        <= pc_in;
         size_m1_ff   <= size_m1_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= tag_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // Key store. The read address follows the next probe position, so the
   // key of the slot under test is ready in the cycle that examines it.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[pos_ff] <= key_ff;
      end
      key_rd_ff <= key_mem[pos_in];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

   // An accepted request always starts the remainder step next.
   `ASSERT_NEXT(a_accept_starts_div, clock, reset, req_accept, pc_ff == STEP_DIV,
                "accept did not start division")
   // A new response only ever comes out of the hand-over step.
   `ASSERT_IMPLIES(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff),
                   $past(pc_ff) == STEP_EMIT, "response raised outside hand-over step")
   // Answers without a slot carry slot index zero.
   `ASSERT_IMPLIES(a_miss_slot_zero, clock, reset,
                   rsp_valid_ff && (rsp_status_ff == ST_FULL || rsp_status_ff == ST_MISS ||
                                    rsp_status_ff == ST_REMOVE_MISS),
                   rsp_slot_ff == '0, "miss answer with nonzero slot")
   // The probe count never runs past the slots in use.
   `ASSERT_IMPLIES(a_probe_bound, clock, reset, pc_ff == STEP_PROBE,
                   cnt_ff <= size_m1_ff && pos_ff <= size_m1_ff, "probe beyond table size")

endmodule

@@ src/lpht_rem.sv @@
// Bit-serial restoring remainder: one dividend bit per cycle.
module lpht_rem
   import lpht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KEY_W-1:0]  dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              busy,
   output logic [SLOT_W-1:0] remainder
);

   localparam int CNT_W = $clog2(KEY_W);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [KEY_W-1:0]  shift_ff, shift_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] div_ff, div_in;
   logic [SIZE_W-1:0] trial;
   logic [SIZE_W-1:0] diff;

   always_comb begin
      trial    = {rem_ff, shift_ff[KEY_W-1]};
      diff     = trial - div_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(KEY_W - 1);
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits a slot index.
         rem_in   = (trial >= div_ff) ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
         shift_in = {shift_ff[KEY_W-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         busy_in  = (cnt_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

@@ dv/testbench.sv @@
module testbench;
   import lpht_pkg::*;

   // One expected response: the status code and the slot it names.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } slot_outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_op;
   logic [KEY_W-1:0]    req_key;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic                csr_wr_en;
   logic [SIZE_W-1:0]   csr_wr_data;

   linear_probe_hash_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // Our own copy of the table: the tag of every slot, the key it holds and the
   // size register. The keys of slots that were never written are never compared.
   logic [TAG_W-1:0]  model_tag [MAX_SLOTS];
   logic [KEY_W-1:0]  model_key [MAX_SLOTS];
   logic [SIZE_W-1:0] model_size;

   // Responses still owed by the block, oldest first.
   slot_outcome_type pending_outcomes [$];

   // Keys that have been inserted lately, so that searches and removes mostly hit.
   logic [KEY_W-1:0] recent_keys [$];

   int requests_sent;
   int responses_checked;
   int fail_count;
   int sizes_written;
   int status_count [0:7];

   // Pacing controls shared between the test tasks and the two sides. When an
   // eager flag is set that side neither idles nor stalls; a non-zero hold count
   // sets the length of the stall the receiver makes after its next response.
   bit req_eager;
   bit rsp_eager;
   int rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a correct run finishes far sooner than this.
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   // Works out the response to one request and applies its effect to the model.
   // The live size is the register clamped to 1..MAX_SLOTS; the home slot is the
   // key modulo that size and probing wraps to slot 0 after the last live slot.
   function automatic slot_outcome_type probe_table(input logic [OP_W-1:0] op,
                                                    input logic [KEY_W-1:0] key);
      int               span;
      int               pos;
      int               n;
      bit               done;
      bit               hit;
      slot_outcome_type res;
      span = int'(model_size);
      if (span == 0) span = 1;
      if (span > MAX_SLOTS) span = MAX_SLOTS;
      pos = {1'b0, key} % span;
      done = 1'b0;
      hit = 1'b0;
      res.status = ST_MISS;
      res.slot = '0;
      case (op)
         OP_INSERT: begin
            // Insert takes the first slot that is not in use, deleted ones
            // included, and never looks for a duplicate.
            res.status = ST_FULL;
            for (n = 0; n < span && !done; n++) begin
               if (model_tag[pos] != TAG_USED) begin
                  model_tag[pos] = TAG_USED;
                  model_key[pos] = key;
                  res.status = ST_INSERTED;
                  res.slot = pos[SLOT_W-1:0];
                  done = 1'b1;
               end else begin
                  pos = (pos + 1 == span) ? 0 : pos + 1;
               end
            end
         end
         OP_SEARCH, OP_REMOVE: begin
            // An empty slot ends the chain; deleted slots are stepped over.
            for (n = 0; n < span && !done; n++) begin
               if (model_tag[pos] == TAG_EMPTY) begin
                  done = 1'b1;
               end else if (model_tag[pos] == TAG_USED && model_key[pos] == key) begin
                  hit = 1'b1;
                  done = 1'b1;
               end else begin
                  pos = (pos + 1 == span) ? 0 : pos + 1;
               end
            end
            if (op == OP_SEARCH) begin
               res.status = hit ? ST_FOUND : ST_MISS;
            end else begin
               res.status = hit ? ST_REMOVED : ST_REMOVE_MISS;
               if (hit) model_tag[pos] = TAG_GONE;
            end
            if (hit) res.slot = pos[SLOT_W-1:0];
         end
         default: begin
            // The unused opcode leaves the table alone and reports a miss.
         end
      endcase
      return res;
   endfunction

   // Monitor and checker. Everything is sampled at the rising edge, so both the
   // values we drive and those the block drives are seen as they were before the
   // edge. A request accepted at this edge is predicted at once; a response
   // accepted at this edge is compared with the oldest prediction.
   always @(posedge clock) begin
      slot_outcome_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_outcomes.push_back(probe_table(req_op, req_key));
         end
         if (rsp_valid && !rsp_stall) begin
            responses_checked++;
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Response with no request outstanding: status %0d slot %0d",
                           rsp_status, rsp_slot_index);
               end
            end else begin
               want = pending_outcomes.pop_front();
               status_count[want.status]++;
               if (rsp_status !== want.status || rsp_slot_index !== want.slot) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Mismatch on response %0d: expected status %0d slot %0d, ",
                              responses_checked, want.status, want.slot,
                              "got status %0d slot %0d", rsp_status, rsp_slot_index);
                  end
               end
            end
         end
      end
   end

   // Response side. Before each response it stalls for a random stretch that may be
   // empty, not at all in an eager stretch, or for a long hold-off when one has been asked for.
   // It then lowers stall and waits for the block to present a response.
   initial begin
      int wait_n;
      forever begin
         if (rsp_hold_cycles > 0) begin
            wait_n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (rsp_eager) begin
            wait_n = 0;
         end else begin
            wait_n = $urandom_range(0, 19);
         end
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offers one request and returns at the edge where it is accepted, with valid
   // still high. The next call either keeps valid up with new contents in that
   // same step or lowers it for its idle gap, so valid is assigned only once.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // Withdraws valid and waits until every request sent so far has been answered.
   // Each request gives exactly one response, so the block is then idle.
   task automatic settle_requests();
      req_valid <= 1'b0;
      while (responses_checked < requests_sent) @(posedge clock);
   endtask

   // Writes the size register; only ever called while the block is idle.
   task automatic write_table_size(input logic [SIZE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      model_size = value;
      sizes_written++;
   endtask

   // Basic probing at the reset size of ten: a miss on the empty table, a home
   // slot collision, the largest key, a remove that leaves a deleted slot which
   // later searches step over, a second remove of the same key, the unused
   // opcode, and an insert that reuses the deleted slot.
   task automatic test_basic_probing();
      send_request(OP_SEARCH, 31'd0);
      send_request(OP_INSERT, 31'd0);
      send_request(OP_INSERT, 31'd10);
      send_request(OP_INSERT, 31'h7FFF_FFFF);
      send_request(OP_SEARCH, 31'd10);
      send_request(OP_REMOVE, 31'd0);
      send_request(OP_SEARCH, 31'd10);
      send_request(OP_REMOVE, 31'd0);
      send_request(OP_UNUSED, 31'h5555_5555);
      send_request(OP_INSERT, 31'd20);
      settle_requests();
   endtask

   // Size changes while the table is in use. Shrinking to two leaves the upper
   // slots untouched but unprobed and fills the table, so an insert reports full
   // and a remove gives up after probing every slot. A size of zero behaves as
   // one, and a size above the maximum behaves as the maximum.
   task automatic test_size_extremes();
      write_table_size(5'd2);
      send_request(OP_INSERT, 31'd3);
      send_request(OP_REMOVE, 31'd9);
      send_request(OP_SEARCH, 31'd10);
      send_request(OP_REMOVE, 31'd20);
      send_request(OP_INSERT, 31'd3);
      settle_requests();
      write_table_size(5'd0);
      send_request(OP_INSERT, 31'd4);
      send_request(OP_SEARCH, 31'd3);
      send_request(OP_REMOVE, 31'd3);
      send_request(OP_INSERT, 31'd4);
      settle_requests();
      write_table_size(5'd31);
      send_request(OP_INSERT, 31'h7FFF_FFFF);
      send_request(OP_SEARCH, 31'h7FFF_FFFF);
      send_request(OP_UNUSED, 31'h7FFF_FFFF);
      send_request(OP_SEARCH, 31'd5);
      settle_requests();
   endtask

   // Back-pressure: the receiver holds off for a long stretch while the sender
   // offers requests without a gap, so the output register and the engine both
   // fill and the block must stall its request input until the receiver drains.
   task automatic test_response_holdoff();
      int i;
      req_eager = 1'b1;
      rsp_hold_cycles = 400;
      for (i = 0; i < 12; i++) begin
         send_request((i % 3 == 2) ? OP_SEARCH : OP_INSERT, 31'(i * 7 + 1));
      end
      req_eager = 1'b0;
      settle_requests();
   endtask

   // Random traffic over a range of sizes, including zero and sizes beyond the
   // maximum. Half the keys come from those inserted lately, so that searches and
   // removes find things and the table fills and empties; the rest are small
   // keys that crowd the low slots and full-width keys. Every twenty requests
   // each side picks whether to run flat out or with random pauses, and in some
   // phases the sender stops half way until all responses are in.
   task automatic test_random_traffic();
      logic [SIZE_W-1:0] phase_sizes [10];
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      int                p;
      int                i;
      int                r;
      phase_sizes = '{5'd3, 5'd16, 5'd1, 5'd7, 5'd0, 5'd5, 5'd31, 5'd12, 5'd2, 5'd10};
      for (p = 0; p < 10; p++) begin
         settle_requests();
         write_table_size(phase_sizes[p]);
         for (i = 0; i < 160; i++) begin
            if (i % 20 == 0) begin
               req_eager = ($urandom_range(0, 3) == 0);
               rsp_eager = ($urandom_range(0, 3) == 0);
            end
            if (i == 80 && p % 3 == 1) begin
               settle_requests();
            end
            r = $urandom_range(0, 99);
            if (r < 38) op = OP_INSERT;
            else if (r < 68) op = OP_SEARCH;
            else if (r < 95) op = OP_REMOVE;
            else op = OP_UNUSED;
            r = $urandom_range(0, 99);
            if (r < 50 && recent_keys.size() > 0) begin
               key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            end else if (r < 70) begin
               key = 31'($urandom_range(0, 40));
            end else begin
               key = 31'($urandom);
            end
            if (op == OP_INSERT) begin
               recent_keys.push_back(key);
               if (recent_keys.size() > 24) void'(recent_keys.pop_front());
            end
            send_request(op, key);
         end
      end
      req_eager = 1'b0;
      rsp_eager = 1'b0;
   endtask

   initial begin
      int s;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_op      <= OP_INSERT;
      req_key     <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_eager = 1'b0;
      rsp_eager = 1'b0;
      rsp_hold_cycles = 0;
      requests_sent = 0;
      responses_checked = 0;
      fail_count = 0;
      sizes_written = 0;
      for (s = 0; s < 8; s++) status_count[s] = 0;
      // After reset every slot is empty and the size register reads ten.
      model_size = SIZE_RESET;
      for (s = 0; s < MAX_SLOTS; s++) begin
         model_tag[s] = TAG_EMPTY;
         model_key[s] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_probing();
      test_size_extremes();
      test_response_holdoff();
      test_random_traffic();

      // Let the last responses arrive, then watch a while longer for strays.
      settle_requests();
      repeat (64) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         fail_count++;
         $display("%0d expected responses never arrived", pending_outcomes.size());
      end

      $display("Checked %0d responses to %0d requests across %0d size settings.",
               responses_checked, requests_sent, sizes_written);
      $display("Inserted %0d, full %0d, found %0d, ",
               status_count[ST_INSERTED], status_count[ST_FULL], status_count[ST_FOUND],
               "not found %0d, removed %0d, remove miss %0d.",
               status_count[ST_MISS], status_count[ST_REMOVED], status_count[ST_REMOVE_MISS]);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
